// File: design/rcfv_pkg.sv
// Package for the RC frame validator: configuration and stream word types,
// register indexes, framing constants and the CRC-8 byte update.
// No dependencies; imported by the input register, the checker and the top level.
`timescale 1ns / 1ps

package rcfv_pkg;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned POS_W     = 9;
  localparam int unsigned COUNT_W   = POS_W + 1;

  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_PRIMARY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_ALTERNATE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD    = 2'd2;

  localparam logic [7:0] SYNC_PRIMARY_RST   = 8'd200;
  localparam logic [7:0] SYNC_ALTERNATE_RST = 8'd238;
  localparam logic [7:0] MAX_PAYLOAD_RST    = 8'd60;

  localparam logic [7:0]         CRC_POLY  = 8'hD5;
  localparam logic [7:0]         TYPE_BAD  = 8'hFF;
  localparam logic [7:0]         LEN_MIN   = 8'd2;
  localparam logic [COUNT_W-1:0] MIN_BYTES = 10'd4;
  localparam logic [POS_W-1:0]   POS_MAX   = 9'd511;

  typedef struct packed {
    logic [7:0] sync_primary;
    logic [7:0] sync_alternate;
    logic [7:0] max_payload;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_word_t;

  // One byte through the MSB-first CRC-8, eight shift steps.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: design/rcfv_byte_if.sv
// Stream interface carrying one buffer byte and its last marker per word.
// Depends on nothing; used by the validator top level.
`timescale 1ns / 1ps

interface rcfv_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// File: design/rcfv_result_if.sv
// Stream interface carrying one frame check result per word.
// Depends on nothing; used by the validator top level.
`timescale 1ns / 1ps

interface rcfv_result_if;
  logic       valid;
  logic       ready;
  logic       frame_valid;
  logic [7:0] frame_type;

  modport source (output valid, output frame_valid, output frame_type, input ready);
  modport sink (input valid, input frame_valid, input frame_type, output ready);
endinterface

// File: design/rcfv_in_stage.sv
// Input register of the validator: captures one byte word per cycle while the checker takes words.
// Depends on rcfv_pkg.
`timescale 1ns / 1ps

module rcfv_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rcfv_pkg::byte_word_t in_word_i,
  output logic                word_valid_o,
  input  logic                word_ready_i,
  output rcfv_pkg::byte_word_t word_o
);
  import rcfv_pkg::*;

  logic       valid_q, valid_d;
  byte_word_t word_q;
  logic       load;

  assign in_ready_o = !valid_q || word_ready_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (word_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q <= in_word_i;
    end
  end

  assign word_valid_o = valid_q;
  assign word_o       = word_q;
endmodule

// File: design/rcfv_checker.sv
// Frame state and result register: tracks header, length and CRC byte by byte
// and registers the verdict on the last byte. Depends on rcfv_pkg.
`timescale 1ns / 1ps

module rcfv_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rcfv_pkg::cfg_t       cfg_i,
  input  logic                 word_valid_i,
  output logic                 word_ready_o,
  input  rcfv_pkg::byte_word_t word_i,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output logic                 frame_valid_o,
  output logic [7:0]           frame_type_o
);
  import rcfv_pkg::*;

  logic [POS_W-1:0]   pos_q, pos_d;
  logic [7:0]         len_q, len_n;
  logic [7:0]         crc_q, crc_n;
  logic               hdr_q, hdr_n;
  logic [7:0]         type_q, type_n;
  logic               chk_q, chk_n;
  logic               res_valid_q, res_valid_d;
  logic               res_fv_q, res_fv_d;
  logic [7:0]         res_type_q, res_type_d;
  logic               fire;
  logic [7:0]         b;
  logic [COUNT_W-1:0] count;
  logic               size_ok;

  // A word that produces no result never waits on the output side.
  assign word_ready_o = !word_i.last_byte || !res_valid_q || res_ready_i;
  assign fire         = word_valid_i && word_ready_o;
  assign b            = word_i.data_byte;

  always_comb begin
    hdr_n  = hdr_q;
    len_n  = len_q;
    crc_n  = crc_q;
    type_n = type_q;
    chk_n  = chk_q;
    if (pos_q == '0) begin
      hdr_n = (b == cfg_i.sync_primary) || (b == cfg_i.sync_alternate);
    end else if (pos_q == 9'd1) begin
      len_n = b;
      if (b < LEN_MIN || {1'b0, b} > ({1'b0, cfg_i.max_payload} + 9'd2)) begin
        hdr_n = 1'b0;
      end
    end else begin
      if (pos_q == 9'd2) begin
        type_n = b;
      end
      if (pos_q <= {1'b0, len_q}) begin
        crc_n = crc8_byte(crc_q, b);
      end else if (pos_q == ({1'b0, len_q} + 9'd1)) begin
        chk_n = (crc_q == b);
      end
    end
  end

  assign count   = {1'b0, pos_q} + 10'd1;
  assign size_ok = hdr_n && (count >= MIN_BYTES);
  assign pos_d   = (pos_q == POS_MAX) ? pos_q : pos_q + 9'd1;

  always_comb begin
    res_valid_d = res_valid_q;
    res_fv_d    = res_fv_q;
    res_type_d  = res_type_q;
    if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
    if (fire && word_i.last_byte) begin
      res_valid_d = 1'b1;
      res_fv_d    = size_ok && (count >= ({2'b00, len_n} + 10'd2)) && chk_n &&
                    (type_n != TYPE_BAD);
      res_type_d  = size_ok ? type_n : TYPE_BAD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      len_q       <= '0;
      crc_q       <= '0;
      hdr_q       <= 1'b0;
      type_q      <= TYPE_BAD;
      chk_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      if (fire) begin
        if (word_i.last_byte) begin
          pos_q  <= '0;
          len_q  <= '0;
          crc_q  <= '0;
          hdr_q  <= 1'b0;
          type_q <= TYPE_BAD;
          chk_q  <= 1'b0;
        end else begin
          pos_q  <= pos_d;
          len_q  <= len_n;
          crc_q  <= crc_n;
          hdr_q  <= hdr_n;
          type_q <= type_n;
          chk_q  <= chk_n;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_fv_q   <= res_fv_d;
    res_type_q <= res_type_d;
  end

  assign res_valid_o   = res_valid_q;
  assign frame_valid_o = res_fv_q;
  assign frame_type_o  = res_type_q;
endmodule

// File: design/rc_frame_validator.sv
// Top level of the RC frame validator: configuration registers, input
// register and frame checker. Depends on rcfv_pkg, rcfv_byte_if,
// rcfv_result_if, rcfv_in_stage and rcfv_checker.
// Usage: bytes of a received buffer enter on in_byte, one word per cycle while
// in_byte.ready is high, with last_byte set on the final byte of the buffer. For every buffer one
// result word leaves on out_result: frame_valid and the frame type (255 when
// the header is bad or the buffer is too short). Bytes without the last mark
// produce nothing.
// A last byte accepted into the input register moves on to the result register
// once the output is free, and its result word is then offered on out_result.
// Bytes flow at one per cycle while no stall holds them, set by the single pass of
// header, length and eight-step CRC logic between the two registers.
// The sync bytes and the largest payload are written through cfg_we_i,
// cfg_idx_i and cfg_data_i; the user must write them only while no buffer is in
// flight, which the block itself does not enforce; other indexes are ignored.
// Reset clears the frame state and restores the register defaults (200, 238,
// 60); no result is pending afterwards.
// When the receiver stalls, the result word holds; non-final bytes keep
// flowing, and a final byte waits in the input register until the result
// has been taken.
`timescale 1ns / 1ps

module rc_frame_validator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  rcfv_byte_if.sink                        in_byte,
  rcfv_result_if.source                    out_result,
  input  logic                             cfg_we_i,
  input  logic [rcfv_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [7:0]                       cfg_data_i
);
  import rcfv_pkg::*;

  cfg_t       cfg_q, cfg_d;
  byte_word_t in_word, word;
  logic       word_valid, word_ready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SYNC_PRIMARY:   cfg_d.sync_primary   = cfg_data_i;
        CFG_SYNC_ALTERNATE: cfg_d.sync_alternate = cfg_data_i;
        CFG_MAX_PAYLOAD:    cfg_d.max_payload    = cfg_data_i;
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_primary   <= SYNC_PRIMARY_RST;
      cfg_q.sync_alternate <= SYNC_ALTERNATE_RST;
      cfg_q.max_payload    <= MAX_PAYLOAD_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign in_word.data_byte = in_byte.data_byte;
  assign in_word.last_byte = in_byte.last_byte;

  rcfv_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_byte.valid),
    .in_ready_o   (in_byte.ready),
    .in_word_i    (in_word),
    .word_valid_o (word_valid),
    .word_ready_i (word_ready),
    .word_o       (word)
  );

  rcfv_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .word_valid_i  (word_valid),
    .word_ready_o  (word_ready),
    .word_i        (word),
    .res_valid_o   (out_result.valid),
    .res_ready_i   (out_result.ready),
    .frame_valid_o (out_result.frame_valid),
    .frame_type_o  (out_result.frame_type)
  );
endmodule

// File: design/rcfv_sva.sv
// Port-level checks for the RC frame validator, bound to its top level.
// Depends on rc_frame_validator.
`timescale 1ns / 1ps

module rcfv_sva (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       in_last_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       out_frame_valid_i,
  input logic [7:0] out_frame_type_i
);

  // A stalled result word must stay offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  // A good frame never reports the reserved type.
  a_good_type: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_frame_valid_i |-> out_frame_type_i != 8'hFF)
    else $error("valid frame reported with reserved type");

  // A final byte taken at the input is expected to be followed by an offered result word.
  a_last_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_last_i |-> ##2 out_valid_i)
    else $error("no result after final byte");

  // Nothing is offered straight out of reset.
  a_reset_idle: assert property (@(posedge clk_i)
    !$past(rst_ni) |-> !out_valid_i)
    else $error("result offered after reset");

endmodule

bind rc_frame_validator rcfv_sva u_rcfv_sva (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_byte.valid),
  .in_ready_i        (in_byte.ready),
  .in_last_i         (in_byte.last_byte),
  .out_valid_i       (out_result.valid),
  .out_ready_i       (out_result.ready),
  .out_frame_valid_i (out_result.frame_valid),
  .out_frame_type_i  (out_result.frame_type)
);
